// File: rtl/wbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared widths, register indexes and the result record of the scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
    localparam int DEFAULT_OFFSET_BITS       = 32;

    // Fixed widths of the register file and of the stream payloads.
    localparam int ADDR_W        = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int LEN_W         = 5;
    localparam int PATTERN_SLOTS = 16;
    localparam int PIDX_W        = 4;
    localparam int BYTE_W        = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Register indexes of the configuration channel.
    localparam t_cfg_index CFG_PATTERN_LOW  = 3'd0;
    localparam t_cfg_index CFG_PATTERN_HIGH = 3'd1;
    localparam t_cfg_index CFG_WILDCARD     = 3'd2;
    localparam t_cfg_index CFG_LENGTH       = 3'd3;
    localparam t_cfg_index CFG_BASE_ADDR    = 3'd4;

    // One result item as it travels through the output queue.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              matched;
        logic              done;
    } t_result;

endpackage : wbps_pkg
`default_nettype wire

// File: rtl/wbps_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: masked window compare
// Compares the newest window bytes against the pattern, honoring wildcards.
// ----------------------------------------------------------------------------
module wbps_matcher import wbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
    input  wire logic [MAX_PATTERN_BYTES*BYTE_W-1:0] i_window,   // entry 0 is the newest byte
    input  wire logic [PATTERN_SLOTS*BYTE_W-1:0]     i_pattern,
    input  wire logic [PATTERN_SLOTS-1:0]            i_wildcard,
    input  wire logic [LEN_W-1:0]                    i_length,   // already clamped to 1..max
    output logic                                     o_hit
);

    // Window entry j lines up with pattern byte (length - 1 - j).
    always_comb begin
        logic [PIDX_W-1:0] pidx;
        logic              miss;
        miss = 1'b0;
        pidx = '0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            pidx = PIDX_W'(i_length - LEN_W'(1) - LEN_W'(j));
            if ((LEN_W'(j) < i_length) && !i_wildcard[pidx] &&
                (i_pattern[pidx*BYTE_W +: BYTE_W] != i_window[j*BYTE_W +: BYTE_W])) begin
                miss = 1'b1;
            end
        end
        o_hit = !miss;
    end

endmodule : wbps_matcher
`default_nettype wire

// File: rtl/wbps_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: output queue
// Two-entry result queue that decouples the scan from the result stream.
// ----------------------------------------------------------------------------
module wbps_out_fifo import wbps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule : wbps_out_fifo
`default_nettype wire

// File: rtl/wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Streams the bytes of a memory region through a shift window, compares the
// newest bytes against a masked pattern and reports the address of each match.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  --------------------------------
//  s_*       in         s_tvalid/s_tready   data_byte in tdata, region_end
//                                           as tlast
//  m_*       out        m_tvalid/m_tready   match_address in tdata, matched
//                                           as tuser, scan_done as tlast
//  cfg       in         i_cfg_valid/        register index and 64-bit data
//                       o_cfg_ready
//
// Timing: one byte is accepted per clock while s_tready is high. The compare
// and the window shift happen in the accept cycle, the address add in the
// cycle after; the result then goes through the output queue to m_*.
// Bytes that give no result (no match, not the region end) produce no
// transaction on m_*.
// Reset (i_rst_n low, synchronous) clears the window, the byte counter, the
// queue and the registers (pattern length resets to one).
// When m_tready is held low, two results queue up plus one in the add stage;
// s_tready falls only once all three places are taken.
// The configuration channel is always ready; write it only while idle.
//
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEFAULT_OFFSET_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Byte stream in.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,     // [7:0] data_byte
    input  wire logic                  s_tlast,     // region_end

    // Result stream out.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [ADDR_W-1:0]          m_tdata,     // [63:0] match_address
    output logic                       m_tuser,     // [0] matched
    output logic                       m_tlast,     // scan_done

    // Configuration writes.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]    r_pat_lo;
    logic [CFG_DATA_W-1:0]    r_pat_hi;
    logic [PATTERN_SLOTS-1:0] r_mask;
    logic [LEN_W-1:0]         r_len;
    logic [ADDR_W-1:0]        r_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_mask   <= '0;
            r_len    <= LEN_W'(1);
            r_base   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                CFG_WILDCARD:     r_mask   <= i_cfg_data[PATTERN_SLOTS-1:0];
                CFG_LENGTH:       r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_ADDR:    r_base   <= i_cfg_data;
                default:          ;  // Unknown index: the write is dropped.
            endcase
        end
    end

    // The effective length is clamped to 1..MAX_PATTERN_BYTES. A zero length
    // behaves as a single-byte pattern.
    logic [LEN_W-1:0] len_eff;

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN_BYTES)) begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = r_len;
        end
    end

    // ------------------------------------------------------------------------
    // Scan stage: window shift, saturating byte count and masked compare.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0]                   r_window [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0]              r_seen;
    logic [MAX_PATTERN_BYTES*BYTE_W-1:0] n_window;
    logic [OFFSET_BITS-1:0]              n_seen;
    logic                                s_accept;
    logic                                cmp_hit;
    logic                                hit;
    logic [OFFSET_BITS-1:0]              offset;

    assign s_accept = s_tvalid && s_tready;

    // The compare sees the window as it stands once the new byte is in.
    always_comb begin
        n_window[BYTE_W-1:0] = s_tdata;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            n_window[j*BYTE_W +: BYTE_W] = r_window[j-1];
        end
    end

    // The counter holds at its all-ones value once it gets there.
    assign n_seen = (r_seen == '1) ? r_seen : r_seen + OFFSET_BITS'(1);

    wbps_matcher #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_matcher (
        .i_window   (n_window),
        .i_pattern  ({r_pat_hi, r_pat_lo}),
        .i_wildcard (r_mask),
        .i_length   (len_eff),
        .o_hit      (cmp_hit)
    );

    // No match is possible before a full pattern length of the region has
    // arrived; the match starts length - 1 bytes before the current one.
    assign hit    = cmp_hit && (n_seen >= OFFSET_BITS'(len_eff));
    assign offset = n_seen - OFFSET_BITS'(len_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                r_window[j] <= '0;
            end
            r_seen <= '0;
        end else if (s_accept) begin
            // The last byte of a region starts the next one from a clean window.
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                r_window[j] <= s_tlast ? '0 : n_window[j*BYTE_W +: BYTE_W];
            end
            r_seen <= s_tlast ? '0 : n_seen;
        end
    end

    // ------------------------------------------------------------------------
    // Address stage: holds a pending result and adds the base address.
    // ------------------------------------------------------------------------
    logic                   r_p1_valid;
    logic                   r_p1_hit;
    logic                   r_p1_last;
    logic [OFFSET_BITS-1:0] r_p1_offset;
    logic                   fifo_full;
    logic                   fifo_push;
    t_result                n_result;
    t_result                out_result;

    assign fifo_push = r_p1_valid && !fifo_full;
    assign s_tready  = !r_p1_valid || fifo_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (s_accept) begin
            r_p1_valid <= hit || s_tlast;
        end else if (fifo_push) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_p1_hit    <= hit;
            r_p1_last   <= s_tlast;
            r_p1_offset <= offset;
        end
    end

    // A done result without a match reports address zero.
    always_comb begin
        n_result.addr    = r_p1_hit ? r_base + ADDR_W'(r_p1_offset) : '0;
        n_result.matched = r_p1_hit;
        n_result.done    = r_p1_last;
    end

    wbps_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (n_result),
        .o_full  (fifo_full),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (out_result)
    );

    assign m_tdata = out_result.addr;
    assign m_tuser = out_result.matched;
    assign m_tlast = out_result.done;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A region end always restarts the byte count.
    a_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_tlast |=> r_seen == '0)
        else $error("byte count not cleared after region end");

    // The count never wraps once saturated within a region.
    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !s_tlast && (r_seen == '1) |=> r_seen == '1)
        else $error("byte count wrapped");

    // The add stage only ever holds an item that produces a result.
    a_p1_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_p1_hit || r_p1_last))
        else $error("add stage holds an item without a result");

    // The input side stalls only while the add stage waits on a full queue.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_p1_valid && fifo_full))
        else $error("input stalled without a full output queue");

    // A result that is not a match carries address zero.
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-match result with nonzero address");

endmodule : wildcard_byte_pattern_scanner
`default_nettype wire

// File: dv/wbps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner checker
// Follows register writes and accepted bytes on the scanner's channels, keeps
// its own copy of the window, and compares every result transaction with the
// oldest predicted report.
// ----------------------------------------------------------------------------
module wbps_checker import wbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEFAULT_OFFSET_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,     // [7:0] data_byte
    input  wire logic                  s_tlast,     // region_end
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [ADDR_W-1:0]     m_tdata,     // [63:0] match_address
    input  wire logic                  m_tuser,     // [0] matched
    input  wire logic                  m_tlast,     // scan_done
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    logic [CFG_DATA_W-1:0]    pattern_lo;
    logic [CFG_DATA_W-1:0]    pattern_hi;
    logic [PATTERN_SLOTS-1:0] wild_bits;
    logic [LEN_W-1:0]         length_field;
    logic [ADDR_W-1:0]        base_addr;

    logic [BYTE_W-1:0]        window [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0]   seen_count;

    t_result                  expected_reports [$];
    t_result                  want;
    int                       mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Length zero behaves as one; anything above the window size is clamped.
    function automatic int unsigned active_length();
        int unsigned n;
        n = length_field;
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_PATTERN_BYTES) begin
            n = MAX_PATTERN_BYTES;
        end
        return n;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("ERROR: %s", msg);
        end
        mismatch_count++;
    endtask

    // Shifts one byte into the window and queues the report it causes, if any.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned         len;
        logic                hit;
        logic [2*CFG_DATA_W-1:0] pattern_bytes;
        t_result             rep;
        len = active_length();
        pattern_bytes = {pattern_hi, pattern_lo};
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) begin
            window[i] = window[i-1];
        end
        window[0] = b;
        if (seen_count != '1) begin
            seen_count++;
        end
        hit = (seen_count >= len);
        for (int k = 0; k < int'(len); k++) begin
            if (!wild_bits[k] && pattern_bytes[8*k +: 8] != window[int'(len) - 1 - k]) begin
                hit = 1'b0;
            end
        end
        rep.addr    = hit ? base_addr + (ADDR_W'(seen_count) - ADDR_W'(len)) : '0;
        rep.matched = hit;
        rep.done    = last;
        if (last) begin
            foreach (window[i]) window[i] = '0;
            seen_count = '0;
        end
        if (hit || last) begin
            expected_reports.insert(expected_reports.size(), rep);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pattern_lo   = '0;
            pattern_hi   = '0;
            wild_bits    = '0;
            length_field = LEN_W'(1);
            base_addr    = '0;
            foreach (window[i]) window[i] = '0;
            seen_count   = '0;
            expected_reports.delete();
        end else begin
            // A result leaves only after its byte has passed the add stage, so
            // results are matched before this edge's byte adds a new prediction.
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    note_mismatch($sformatf("result with no prediction: addr %h matched %b done %b",
                                            m_tdata, m_tuser, m_tlast));
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata !== want.addr) begin
                        note_mismatch($sformatf("match_address expected %h, got %h",
                                                want.addr, m_tdata));
                    end
                    if (m_tuser !== want.matched) begin
                        note_mismatch($sformatf("matched expected %b, got %b",
                                                want.matched, m_tuser));
                    end
                    if (m_tlast !== want.done) begin
                        note_mismatch($sformatf("scan_done expected %b, got %b",
                                                want.done, m_tlast));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PATTERN_LOW:  pattern_lo   = i_cfg_data;
                    CFG_PATTERN_HIGH: pattern_hi   = i_cfg_data;
                    CFG_WILDCARD:     wild_bits    = i_cfg_data[PATTERN_SLOTS-1:0];
                    CFG_LENGTH:       length_field = i_cfg_data[LEN_W-1:0];
                    CFG_BASE_ADDR:    base_addr    = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule : wbps_checker

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner testbench
// Drives byte regions and register writes into the scanner, with random
// idling on both streams and one long back-pressure stretch; a checker beside
// the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
    import wbps_pkg::*;

    // Cycles to wait after the last expected report before touching the
    // registers; a byte that gives no report may still be in the pipeline.
    localparam int PIPE_DRAIN = 4;
    // Length of the one long receiver hold-off.
    localparam int LONG_HOLD  = 300;
    // First register index that maps to nothing.
    localparam int FIRST_UNMAPPED = int'(CFG_BASE_ADDR) + 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata     = '0;     // [7:0] data_byte
    logic                  s_tlast     = 1'b0;   // region_end
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [ADDR_W-1:0]     m_tdata;              // [63:0] match_address
    logic                  m_tuser;              // [0] matched
    logic                  m_tlast;              // scan_done
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int reports_pending;
    int checker_errors;

    // Stimulus side view of the current setting, used only to plant pattern
    // occurrences into the generated regions.
    logic [BYTE_W-1:0]        plan_pat [PATTERN_SLOTS];
    logic [PATTERN_SLOTS-1:0] plan_wild;
    int                       plan_len;
    logic [BYTE_W-1:0]        region_bytes [$];

    int bytes_sent    = 0;
    bit steady        = 1'b0;   // set for the closing part: no idling at all
    bit hold_request  = 1'b0;   // asks the receiver for the long hold-off

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    wildcard_byte_pattern_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    wbps_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (reports_pending),
        .o_errors    (checker_errors)
    );

    // Offers one register write and waits for its transaction. The valid is
    // left high so that writes can follow back to back; the caller lowers it.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes every register, optionally followed by a write to an index that
    // maps to nothing, and records the pattern for region generation.
    task automatic load_scan_setup(input logic [CFG_DATA_W-1:0] lo,
                                   input logic [CFG_DATA_W-1:0] hi,
                                   input logic [CFG_DATA_W-1:0] wild_word,
                                   input logic [CFG_DATA_W-1:0] len_word,
                                   input logic [CFG_DATA_W-1:0] base,
                                   input bit                    stray);
        int n;
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_WILDCARD, wild_word);
        write_reg(CFG_LENGTH, len_word);
        write_reg(CFG_BASE_ADDR, base);
        if (stray) begin
            write_reg(t_cfg_index'($urandom_range(FIRST_UNMAPPED, 2**CFG_IDX_W - 1)),
                      {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < PATTERN_SLOTS; k++) begin
            plan_pat[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
        end
        plan_wild = wild_word[PATTERN_SLOTS-1:0];
        n = len_word[LEN_W-1:0];
        if (n == 0) begin
            n = 1;
        end
        if (n > PATTERN_SLOTS) begin
            n = PATTERN_SLOTS;
        end
        plan_len = n;
    endtask

    // Offers one byte and waits for its transaction. With gaps allowed, an
    // idle burst may follow; otherwise valid stays high for the next byte.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input bit gappy);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        if (gappy && !steady && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic send_region(input bit gappy);
        for (int i = 0; i < region_bytes.size(); i++) begin
            send_byte(region_bytes[i], i == region_bytes.size() - 1, gappy);
        end
    endtask

    // Waits until every predicted report has arrived and the pipeline is
    // empty, so that the registers may be written.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Fills region_bytes with at least target bytes. Most of it is planted
    // pattern occurrences (random bytes at wildcard positions), some cut
    // short, some with one byte broken; the rest is random filler. A noise
    // region has no planted content at all.
    task automatic build_region(input int target, input bit noise);
        int pick;
        int cut;
        int flip;
        region_bytes.delete();
        while (region_bytes.size() < target) begin
            pick = $urandom_range(0, 9);
            if (noise || pick >= 6) begin
                region_bytes.insert(region_bytes.size(), BYTE_W'($urandom));
            end else begin
                cut  = (pick < 4) ? plan_len : $urandom_range(1, plan_len);
                flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cut - 1) : -1;
                for (int k = 0; k < cut; k++) begin
                    if (plan_wild[k]) begin
                        region_bytes.insert(region_bytes.size(), BYTE_W'($urandom));
                    end else if (k == flip) begin
                        region_bytes.insert(region_bytes.size(),
                                            plan_pat[k] ^ BYTE_W'(1 << $urandom_range(0, 7)));
                    end else begin
                        region_bytes.insert(region_bytes.size(), plan_pat[k]);
                    end
                end
            end
        end
    endtask

    // One setting followed by about 90 bytes of regions. Kind 0 is the
    // longest pattern with no wildcards at the top address, kind 1 a single
    // wildcard byte that matches everything at address zero; other kinds
    // pick the setting at random, including out-of-range lengths and junk
    // in the unused upper bits of the narrow registers.
    task automatic random_phase(input int kind);
        logic [CFG_DATA_W-1:0]    lo;
        logic [CFG_DATA_W-1:0]    hi;
        logic [CFG_DATA_W-1:0]    base;
        logic [CFG_DATA_W-1:0]    upper;
        logic [PATTERN_SLOTS-1:0] wild;
        logic [LEN_W-1:0]         len;
        int                       phase_bytes;
        int                       target;
        phase_bytes = 0;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LEN_W'($urandom_range(PATTERN_SLOTS + 1, 2**LEN_W - 1));
            2:       len = LEN_W'(PATTERN_SLOTS);
            3:       len = LEN_W'(1);
            default: len = LEN_W'($urandom_range(2, PATTERN_SLOTS - 1));
        endcase
        case ($urandom_range(0, 3))
            0:       wild = '0;
            1:       wild = PATTERN_SLOTS'($urandom);
            2:       wild = PATTERN_SLOTS'($urandom & $urandom);
            default: wild = PATTERN_SLOTS'($urandom & $urandom & $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = {$urandom, $urandom};
        endcase
        if (kind == 0) begin
            len  = LEN_W'(PATTERN_SLOTS);
            wild = '0;
            base = '1;
        end else if (kind == 1) begin
            len  = LEN_W'(1);
            wild = '1;
            base = '0;
        end
        upper = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : '0;
        load_scan_setup(lo, hi, {upper[CFG_DATA_W-1:PATTERN_SLOTS], wild},
                        {upper[CFG_DATA_W-1:LEN_W], len}, base, $urandom_range(0, 3) == 0);
        while (phase_bytes < 90) begin
            target = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            build_region(target, $urandom_range(0, 4) == 0);
            phase_bytes += region_bytes.size();
            send_region($urandom_range(0, 3) != 0);
        end
        settle();
    endtask

    // Receiver: random stall bursts, a stall-free closing part, and the long
    // hold-off on request, counted here while the sender keeps offering bytes.
    // The wait at the top of the loop is the last cycle of each stall.
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: a one-byte pattern of zero at address zero. The
        // region ends on a matching byte, so match and done share a result.
        plan_len  = 1;
        plan_wild = '0;
        region_bytes = '{8'h00, 8'hFF, 8'h00};
        send_region(1'b0);
        settle();

        // Four-byte pattern with a wildcard in the second place and junk in
        // the wildcard bits above the length. The match address wraps past
        // the top of the address space. The short region that follows ends
        // before the pattern can fit and gives only a done report.
        load_scan_setup(64'h0000_0000_EFBE_ADDE, '1, 64'h0000_0000_0000_FFF2,
                        64'd4, '1, 1'b1);
        region_bytes = '{8'h11, 8'hDE, 8'h00, 8'hBE, 8'hEF};
        send_region(1'b0);
        region_bytes = '{8'hDE, 8'hAD};
        send_region(1'b0);
        settle();

        // A length of zero behaves as a length of one.
        load_scan_setup(64'h0000_0000_0000_005A, '0, '0, 64'd0, 64'h1000, 1'b0);
        region_bytes = '{8'h5A, 8'h5A};
        send_region(1'b0);
        settle();

        // A length above the window size is clamped to the full window;
        // with every byte a wildcard, only the sixteenth byte matches.
        load_scan_setup('0, '0, 64'h0000_0000_0000_FFFF, 64'd31,
                        64'h8000_0000_0000_0000, 1'b0);
        region_bytes.delete();
        for (int k = 0; k < PATTERN_SLOTS; k++) begin
            region_bytes.insert(region_bytes.size(), BYTE_W'(k * 17));
        end
        send_region(1'b0);
        settle();

        random_phase(0);
        random_phase(1);

        // Every byte matches while the receiver holds off, so the result
        // queue fills up and the block has to stall its byte input.
        load_scan_setup({$urandom, $urandom}, {$urandom, $urandom}, 64'h1, 64'd1,
                        {$urandom, $urandom}, 1'b0);
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_byte(BYTE_W'($urandom), n == 39, 1'b0);
        end
        settle();

        while (bytes_sent < 1000) begin
            random_phase(2);
        end
        steady = 1'b1;
        while (bytes_sent < 1150) begin
            random_phase(2);
        end

        // settle() has already waited for every report; give the block a
        // few more cycles to show any stray result.
        repeat (4 * PIPE_DRAIN) @(posedge i_clk);
        if (checker_errors == 0 && reports_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Far beyond the slowest correct run; a hang ends here.
    initial begin : watchdog
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule : tb
